// ----- design/smrb_pkg.sv -----
package smrb_pkg;

  localparam int unsigned DEPTH_DEF = 1024;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned GAIN_W    = 15;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned OCC_W     = 11;
  localparam int unsigned PAIR_W    = 2 * SAMPLE_W;
  localparam int unsigned CFG_IDX_W = 2;

  localparam int unsigned GainFull  = 32767;
  localparam int unsigned GainDiv   = 255;

  typedef logic [GAIN_W-1:0] gain_lut_t [256];

  // gain(g) = floor(g * 32767 / 255), built at elaboration
  function automatic gain_lut_t gain_lut_build();
    gain_lut_t lut;
    for (int i = 0; i < 256; i++) begin
      lut[i] = GAIN_W'((i * GainFull) / GainDiv);
    end
    return lut;
  endfunction

  localparam gain_lut_t GAIN_LUT = gain_lut_build();

  typedef struct packed {
    logic                       op;
    logic signed [SAMPLE_W-1:0] fm_left_in;
    logic signed [SAMPLE_W-1:0] fm_right_in;
    logic signed [SAMPLE_W-1:0] psg_in;
  } smrb_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       underflow;
    logic [OCC_W-1:0]           occupancy;
    logic                       ring_full;
  } smrb_out_t;

  typedef struct packed {
    logic wr;
    logic rd;
    logic pop;
  } ring_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

endpackage

// ----- design/stereo_mix_ring_buffer.sv -----
// Stereo mixer in front of a ring of sample pairs.
//
// Input channel (in_valid_i / in_ready_o / in_i) takes one request at a
// time. op 0 mixes FM left/right with mono PSG, each scaled by its volume
// gain, then by the master gain, clamps to 16 bits and stores the pair in
// the ring. op 1 pops the oldest pair, or returns silence with underflow
// set when the ring is empty. A write into a full ring overwrites unread
// data and the ring stays full.
// Output channel (out_valid_o / out_ready_i / out_o) carries one result per
// request, with the occupancy and full flag after that request.
// A mix request makes five passes through the one shared 17x16 multiplier,
// then passes the result and output registers; a read passes the registered
// (synchronous) ring read first, and an underflowing read skips the ring read.
// A new request is taken the cycle after the previous result is loaded into
// the output register. Gain registers are written on cfg_we_i with cfg_idx_i
// / cfg_data_i; the user must do so only while idle, the block does not
// enforce it. Unknown indexes are ignored. Reset empties the ring (pointers
// and full mark cleared, contents left undefined) and sets all gains to 255.
// If the receiver stalls, the finished result waits in the output register
// and the next request is processed up to its result, then held.
module stereo_mix_ring_buffer #(
  parameter int unsigned DEPTH = smrb_pkg::DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  smrb_pkg::smrb_in_t               in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output smrb_pkg::smrb_out_t              out_o,
  input  logic                             cfg_we_i,
  input  logic [smrb_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [smrb_pkg::IDX_W-1:0]       cfg_data_i
);

  localparam int unsigned SW = smrb_pkg::SAMPLE_W;

  localparam logic OP_MIX  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [smrb_pkg::CFG_IDX_W-1:0] CFG_FM     = 2'd0;
  localparam logic [smrb_pkg::CFG_IDX_W-1:0] CFG_PSG    = 2'd1;
  localparam logic [smrb_pkg::CFG_IDX_W-1:0] CFG_MASTER = 2'd2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MIX  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] state_q, state_d;

  // gain indexes
  logic [smrb_pkg::IDX_W-1:0] fm_gain_q, psg_gain_q, master_gain_q;

  // captured request and pending result
  smrb_pkg::smrb_in_t   in_q;
  logic signed [SW-1:0] res_left_q, res_left_d, res_right_q, res_right_d;
  logic                 res_under_q, res_under_d;
  logic                 res_ld;

  // output register
  smrb_pkg::smrb_out_t out_q;
  logic                out_valid_q, out_valid_d;
  logic                out_ld;

  logic accept;

  smrb_pkg::ring_cmd_t          ring_cmd;
  smrb_pkg::ring_stat_t         ring_stat;
  logic [smrb_pkg::PAIR_W-1:0]  ring_rdata;
  logic [smrb_pkg::OCC_W-1:0]   ring_occ;

  logic                 mix_start, mix_done;
  logic signed [SW-1:0] mix_left, mix_right;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign mix_start  = accept && (in_i.op == OP_MIX);

  // ring commands: store the mixed pair, fetch the head on a non-empty read,
  // and advance the read side once the data is back
  assign ring_cmd.wr  = (state_q == ST_MIX) && mix_done;
  assign ring_cmd.rd  = accept && (in_i.op == OP_READ) && !ring_stat.empty;
  assign ring_cmd.pop = (state_q == ST_RD);

  smrb_mix u_mix (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (mix_start),
    .in_i              (in_q),
    .fm_gain_idx_i     (fm_gain_q),
    .psg_gain_idx_i    (psg_gain_q),
    .master_gain_idx_i (master_gain_q),
    .done_o            (mix_done),
    .left_o            (mix_left),
    .right_o           (mix_right)
  );

  smrb_ring #(
    .DEPTH (DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (ring_cmd),
    .wdata_i ({mix_right, mix_left}),
    .rdata_o (ring_rdata),
    .stat_o  (ring_stat),
    .occ_o   (ring_occ)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    res_ld      = 1'b0;
    res_left_d  = res_left_q;
    res_right_d = res_right_q;
    res_under_d = res_under_q;
    out_ld      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.op == OP_MIX) begin
            state_d = ST_MIX;
          end else if (ring_stat.empty) begin
            // underflow: silence, state untouched
            res_ld      = 1'b1;
            res_left_d  = '0;
            res_right_d = '0;
            res_under_d = 1'b1;
            state_d     = ST_DONE;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_MIX: begin
        if (mix_done) begin
          res_ld      = 1'b1;
          res_left_d  = mix_left;
          res_right_d = mix_right;
          res_under_d = 1'b0;
          state_d     = ST_DONE;
        end
      end
      ST_RD: begin
        res_ld      = 1'b1;
        res_left_d  = ring_rdata[SW-1:0];
        res_right_d = ring_rdata[2*SW-1:SW];
        res_under_d = 1'b0;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        // ring pointers have settled; occupancy is read here
        if (!out_valid_q || out_ready_i) begin
          out_ld  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ld) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      out_valid_q   <= 1'b0;
      fm_gain_q     <= '1;
      psg_gain_q    <= '1;
      master_gain_q <= '1;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_FM:     fm_gain_q     <= cfg_data_i;
          CFG_PSG:    psg_gain_q    <= cfg_data_i;
          CFG_MASTER: master_gain_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_i;
    end
    if (res_ld) begin
      res_left_q  <= res_left_d;
      res_right_q <= res_right_d;
      res_under_q <= res_under_d;
    end
    if (out_ld) begin
      out_q.out_left  <= res_left_q;
      out_q.out_right <= res_right_q;
      out_q.underflow <= res_under_q;
      out_q.occupancy <= ring_occ;
      out_q.ring_full <= ring_stat.full;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_under_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.underflow) |->
      ((out_o.out_left == '0) && (out_o.out_right == '0)))
    else $error("underflow result is not silent");

endmodule

// ----- design/smrb_mix.sv -----
module smrb_mix (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  smrb_pkg::smrb_in_t                   in_i,
  input  logic [smrb_pkg::IDX_W-1:0]           fm_gain_idx_i,
  input  logic [smrb_pkg::IDX_W-1:0]           psg_gain_idx_i,
  input  logic [smrb_pkg::IDX_W-1:0]           master_gain_idx_i,
  output logic                                 done_o,
  output logic signed [smrb_pkg::SAMPLE_W-1:0] left_o,
  output logic signed [smrb_pkg::SAMPLE_W-1:0] right_o
);

  localparam int unsigned SW  = smrb_pkg::SAMPLE_W;
  localparam int unsigned GW  = smrb_pkg::GAIN_W;
  localparam int unsigned OPW = SW + 1;
  localparam int unsigned PW  = OPW + GW + 1;

  localparam logic [2:0] STEP_FL = 3'd0;
  localparam logic [2:0] STEP_FR = 3'd1;
  localparam logic [2:0] STEP_PS = 3'd2;
  localparam logic [2:0] STEP_ML = 3'd3;
  localparam logic [2:0] STEP_MR = 3'd4;

  logic              busy_q, busy_d;
  logic [2:0]        step_q, step_d;
  logic              done_q, done_d;
  logic signed [SW-1:0] fl_q, fr_q, ps_q, left_q, right_q;

  logic signed [OPW-1:0] opnd;
  logic [GW-1:0]         gain;
  logic signed [PW-1:0]  prod;
  logic signed [PW-16:0] scaled;
  logic signed [SW-1:0]  clamped;

  // operand and gain select for the one shared multiplier
  always_comb begin
    opnd = {in_i.fm_left_in[SW-1], in_i.fm_left_in};
    gain = smrb_pkg::GAIN_LUT[fm_gain_idx_i];
    unique case (step_q)
      STEP_FL: begin
        opnd = {in_i.fm_left_in[SW-1], in_i.fm_left_in};
        gain = smrb_pkg::GAIN_LUT[fm_gain_idx_i];
      end
      STEP_FR: begin
        opnd = {in_i.fm_right_in[SW-1], in_i.fm_right_in};
        gain = smrb_pkg::GAIN_LUT[fm_gain_idx_i];
      end
      STEP_PS: begin
        opnd = {in_i.psg_in[SW-1], in_i.psg_in};
        gain = smrb_pkg::GAIN_LUT[psg_gain_idx_i];
      end
      STEP_ML: begin
        opnd = {fl_q[SW-1], fl_q} + {ps_q[SW-1], ps_q};
        gain = smrb_pkg::GAIN_LUT[master_gain_idx_i];
      end
      STEP_MR: begin
        opnd = {fr_q[SW-1], fr_q} + {ps_q[SW-1], ps_q};
        gain = smrb_pkg::GAIN_LUT[master_gain_idx_i];
      end
      default: begin
        opnd = {in_i.fm_left_in[SW-1], in_i.fm_left_in};
        gain = smrb_pkg::GAIN_LUT[fm_gain_idx_i];
      end
    endcase
  end

  assign prod   = opnd * $signed({1'b0, gain});
  // floor(prod / 2^15)
  assign scaled = prod[PW-1:15];

  always_comb begin
    if (scaled > $signed((PW-15)'(32767))) begin
      clamped = 16'sh7fff;
    end else if (scaled < -$signed((PW-15)'(32768))) begin
      clamped = 16'sh8000;
    end else begin
      clamped = scaled[SW-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = STEP_FL;
    end else if (busy_q) begin
      if (step_q == STEP_MR) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= STEP_FL;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      case (step_q)
        STEP_FL: fl_q    <= scaled[SW-1:0];
        STEP_FR: fr_q    <= scaled[SW-1:0];
        STEP_PS: ps_q    <= scaled[SW-1:0];
        STEP_ML: left_q  <= clamped;
        STEP_MR: right_q <= clamped;
        default: ;
      endcase
    end
  end

  assign done_o  = done_q;
  assign left_o  = left_q;
  assign right_o = right_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("mix started while busy");

endmodule

// ----- design/smrb_ring.sv -----
module smrb_ring #(
  parameter int unsigned DEPTH = smrb_pkg::DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  smrb_pkg::ring_cmd_t               cmd_i,
  input  logic [smrb_pkg::PAIR_W-1:0]       wdata_i,
  output logic [smrb_pkg::PAIR_W-1:0]       rdata_o,
  output smrb_pkg::ring_stat_t              stat_o,
  output logic [smrb_pkg::OCC_W-1:0]        occ_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned OccW = $clog2(DEPTH + 1);

  logic [smrb_pkg::PAIR_W-1:0] mem_q [DEPTH];
  logic [smrb_pkg::PAIR_W-1:0] rdata_q;
  logic [IdxW-1:0] wr_q, wr_d, rd_q, rd_d, wr_nxt, rd_nxt;
  logic            full_q, full_d;
  logic [OccW-1:0] occ;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem_q[wr_q] <= wdata_i;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem_q[rd_q];
    end
  end

  assign wr_nxt = (wr_q == IdxW'(DEPTH - 1)) ? '0 : wr_q + IdxW'(1);
  assign rd_nxt = (rd_q == IdxW'(DEPTH - 1)) ? '0 : rd_q + IdxW'(1);

  always_comb begin
    wr_d   = wr_q;
    rd_d   = rd_q;
    full_d = full_q;
    if (cmd_i.wr) begin
      wr_d = wr_nxt;
      if (wr_nxt == rd_q) begin
        full_d = 1'b1;
      end
    end
    if (cmd_i.pop) begin
      rd_d   = rd_nxt;
      full_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      full_q <= 1'b0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      full_q <= full_d;
    end
  end

  always_comb begin
    if (full_q) begin
      occ = OccW'(DEPTH);
    end else if (wr_q >= rd_q) begin
      occ = OccW'(wr_q - rd_q);
    end else begin
      occ = OccW'(DEPTH) - OccW'(rd_q - wr_q);
    end
  end

  if (OccW >= smrb_pkg::OCC_W) begin : g_occ_trunc
    assign occ_o = occ[smrb_pkg::OCC_W-1:0];
  end else begin : g_occ_ext
    assign occ_o = smrb_pkg::OCC_W'(occ);
  end

  assign rdata_o      = rdata_q;
  assign stat_o.empty = (wr_q == rd_q) && !full_q;
  assign stat_o.full  = full_q;

  a_pop_clears_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |=> !full_q)
    else $error("full mark still set after a pop");

  a_no_wr_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.wr && (cmd_i.rd || cmd_i.pop)))
    else $error("write overlaps a read access");

endmodule
